FILE: rtl/core/rbfts_pkg.sv
// Shared types and constants for the rigid-body force and torque accumulator.
// Holds register codes, queue sizes and the records passed between the front and back parts.
// No dependencies.
`default_nettype none

package rbfts_pkg;

    localparam int unsigned Q_W       = 32;
    localparam int unsigned SUM_W     = 48;
    localparam int unsigned CFG_IDX_W = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_BOX_LOW_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_HIGH_X = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_LOW_Y  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_HIGH_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_LOW_Z  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_HIGH_Z = 3'd5;

    // Reset values of the box bounds: -16.0 and +16.0 in Q16.16.
    localparam logic signed [Q_W-1:0] BOX_LOW_RESET  = -32'sd1048576;
    localparam logic signed [Q_W-1:0] BOX_HIGH_RESET = 32'sd1048576;

    localparam logic signed [Q_W-1:0]   Q_MAX   = 32'sh7FFF_FFFF;
    localparam logic signed [Q_W-1:0]   Q_MIN   = 32'sh8000_0000;
    localparam logic signed [SUM_W-1:0] SUM_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [SUM_W-1:0] SUM_MIN = 48'sh8000_0000_0000;

    // Queue between the front and back parts.
    localparam int unsigned MID_DEPTH = 4;
    localparam int unsigned MID_PTR_W = $clog2(MID_DEPTH);
    localparam int unsigned MID_CNT_W = $clog2(MID_DEPTH + 1);

    // Result queue at the output.
    localparam int unsigned OUT_DEPTH = 2;
    localparam int unsigned OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int unsigned OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    typedef logic signed [Q_W-1:0]   q_t;
    typedef logic signed [SUM_W-1:0] sum_t;

    // One classified particle: saturated force and wrapped offset.
    typedef struct packed {
        q_t   fx;
        q_t   fy;
        q_t   fz;
        q_t   rx;
        q_t   ry;
        q_t   rz;
        logic sat;
        logic last;
    } mid_entry_t;

    typedef struct packed {
        logic empty;
        logic full;
    } mid_status_t;

    typedef struct packed {
        sum_t fx;
        sum_t fy;
        sum_t fz;
        sum_t tx;
        sum_t ty;
        sum_t tz;
        logic ovf;
    } result_t;

endpackage

`default_nettype wire

FILE: rtl/core/rbfts_front.sv
// Front part: box registers, particle intake, force product and wrapped offset.
// Depends on rbfts_pkg.
`default_nettype none

module rbfts_front (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_wr_en,
    input  wire logic [rbfts_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [rbfts_pkg::Q_W-1:0]          cfg_data,
    input  wire logic                               in_push,
    output logic                                    in_full,
    input  wire logic [31:0]                        particle_mass,
    input  wire logic signed [31:0]                 accel_x,
    input  wire logic signed [31:0]                 accel_y,
    input  wire logic signed [31:0]                 accel_z,
    input  wire logic signed [31:0]                 pos_x,
    input  wire logic signed [31:0]                 pos_y,
    input  wire logic signed [31:0]                 pos_z,
    input  wire logic signed [31:0]                 centre_x,
    input  wire logic signed [31:0]                 centre_y,
    input  wire logic signed [31:0]                 centre_z,
    input  wire logic                               last_of_body,
    input  wire rbfts_pkg::mid_status_t             mid_status,
    output logic                                    mid_push,
    output rbfts_pkg::mid_entry_t                   mid_entry
);

    rbfts_pkg::q_t box_low_reg  [3];
    rbfts_pkg::q_t box_high_reg [3];

    logic                     a_valid_reg;
    logic signed [63:0]       a_prod_reg [3];
    logic signed [32:0]       a_diff_reg [3];
    logic                     a_last_reg;

    logic                     b_valid_reg;
    rbfts_pkg::mid_entry_t    b_entry_reg;
    rbfts_pkg::mid_entry_t    b_entry_next;

    logic                     adv;
    logic                     accept;
    logic signed [63:0]       prod_in [3];
    logic signed [32:0]       diff_in [3];
    rbfts_pkg::q_t            f_sat [3];
    rbfts_pkg::q_t            r_sat [3];
    logic [2:0]               f_ovf;
    logic [2:0]               r_ovf;

    assign adv      = !b_valid_reg || !mid_status.full;
    assign in_full  = !adv;
    assign accept   = in_push && adv;
    assign mid_push = b_valid_reg && !mid_status.full;
    assign mid_entry = b_entry_reg;

    // Mass is unsigned, so it enters the signed product with a zero on top.
    assign prod_in[0] = 64'($signed({1'b0, particle_mass})) * 64'(accel_x);
    assign prod_in[1] = 64'($signed({1'b0, particle_mass})) * 64'(accel_y);
    assign prod_in[2] = 64'($signed({1'b0, particle_mass})) * 64'(accel_z);
    assign diff_in[0] = 33'(pos_x) - 33'(centre_x);
    assign diff_in[1] = 33'(pos_y) - 33'(centre_y);
    assign diff_in[2] = 33'(pos_z) - 33'(centre_z);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            box_low_reg[0]  <= rbfts_pkg::BOX_LOW_RESET;
            box_low_reg[1]  <= rbfts_pkg::BOX_LOW_RESET;
            box_low_reg[2]  <= rbfts_pkg::BOX_LOW_RESET;
            box_high_reg[0] <= rbfts_pkg::BOX_HIGH_RESET;
            box_high_reg[1] <= rbfts_pkg::BOX_HIGH_RESET;
            box_high_reg[2] <= rbfts_pkg::BOX_HIGH_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                rbfts_pkg::REG_BOX_LOW_X:  box_low_reg[0]  <= cfg_data;
                rbfts_pkg::REG_BOX_HIGH_X: box_high_reg[0] <= cfg_data;
                rbfts_pkg::REG_BOX_LOW_Y:  box_low_reg[1]  <= cfg_data;
                rbfts_pkg::REG_BOX_HIGH_Y: box_high_reg[1] <= cfg_data;
                rbfts_pkg::REG_BOX_LOW_Z:  box_low_reg[2]  <= cfg_data;
                rbfts_pkg::REG_BOX_HIGH_Z: box_high_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    // Force: floor shift by 16, then saturate. Offset: wrap once each way, then saturate.
    always_comb begin
        logic signed [47:0] fs;
        logic signed [35:0] r0;
        logic signed [35:0] r1;
        logic signed [35:0] r2;
        logic signed [35:0] hi36;
        logic signed [35:0] lo36;
        logic signed [35:0] len36;
        for (int i = 0; i < 3; i++)
        begin
            fs = a_prod_reg[i][63:16];
            if ((&fs[47:31]) || !(|fs[47:31]))
            begin
                f_sat[i] = fs[31:0];
                f_ovf[i] = 1'b0;
            end
            else
            begin
                f_sat[i] = fs[47] ? rbfts_pkg::Q_MIN : rbfts_pkg::Q_MAX;
                f_ovf[i] = 1'b1;
            end

            hi36  = 36'(box_high_reg[i]);
            lo36  = 36'(box_low_reg[i]);
            len36 = hi36 - lo36;
            r0    = 36'(a_diff_reg[i]);
            r1    = (r0 >= hi36) ? r0 - len36 : r0;
            r2    = (r1 < lo36) ? r1 + len36 : r1;
            if ((&r2[35:31]) || !(|r2[35:31]))
            begin
                r_sat[i] = r2[31:0];
                r_ovf[i] = 1'b0;
            end
            else
            begin
                r_sat[i] = r2[35] ? rbfts_pkg::Q_MIN : rbfts_pkg::Q_MAX;
                r_ovf[i] = 1'b1;
            end
        end
        b_entry_next.fx   = f_sat[0];
        b_entry_next.fy   = f_sat[1];
        b_entry_next.fz   = f_sat[2];
        b_entry_next.rx   = r_sat[0];
        b_entry_next.ry   = r_sat[1];
        b_entry_next.rz   = r_sat[2];
        b_entry_next.sat  = (|f_ovf) || (|r_ovf);
        b_entry_next.last = a_last_reg;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= accept;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (accept)
        begin
            a_prod_reg <= prod_in;
            a_diff_reg <= diff_in;
            a_last_reg <= last_of_body;
        end
        if (adv)
        begin
            b_entry_reg <= b_entry_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/rbfts_fifo.sv
// Short queue of classified particles between the front and back parts.
// Depends on rbfts_pkg.
`default_nettype none

module rbfts_fifo (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   wr_en,
    input  wire rbfts_pkg::mid_entry_t  wr_data,
    input  wire logic                   rd_en,
    output rbfts_pkg::mid_entry_t       rd_data,
    output rbfts_pkg::mid_status_t      status
);

    rbfts_pkg::mid_entry_t                  mem_reg [rbfts_pkg::MID_DEPTH];
    logic [rbfts_pkg::MID_PTR_W-1:0]        wr_ptr_reg;
    logic [rbfts_pkg::MID_PTR_W-1:0]        rd_ptr_reg;
    logic [rbfts_pkg::MID_CNT_W-1:0]        cnt_reg;
    logic [rbfts_pkg::MID_CNT_W-1:0]        cnt_next;
    logic                                   do_wr;
    logic                                   do_rd;

    assign status.empty = (cnt_reg == '0);
    assign status.full  = (cnt_reg == rbfts_pkg::MID_CNT_W'(rbfts_pkg::MID_DEPTH));
    assign do_wr        = wr_en && !status.full;
    assign do_rd        = rd_en && !status.empty;
    assign rd_data      = mem_reg[rd_ptr_reg];

    always_comb begin
        cnt_next = cnt_reg;
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/rbfts_back.sv
// Back part: torque products, cross differences, saturating sums and the result queue.
// Depends on rbfts_pkg.
`default_nettype none

module rbfts_back (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire rbfts_pkg::mid_entry_t  mid_entry,
    input  wire rbfts_pkg::mid_status_t mid_status,
    output logic                        mid_pop,
    input  wire logic                   res_pop,
    output logic                        res_empty,
    output rbfts_pkg::result_t          res_data
);

    // Product stage.
    logic                   c_valid_reg;
    logic signed [63:0]     c_prod_reg [6];
    rbfts_pkg::q_t          c_f_reg [3];
    logic                   c_sat_reg;
    logic                   c_last_reg;
    logic signed [63:0]     c_prod_next [6];

    // Term stage.
    logic                   d_valid_reg;
    logic signed [48:0]     d_tq_reg [3];
    rbfts_pkg::q_t          d_f_reg [3];
    logic                   d_sat_reg;
    logic                   d_last_reg;
    logic signed [48:0]     d_tq_next [3];

    // Sums.
    rbfts_pkg::sum_t        force_acc_reg [3];
    rbfts_pkg::sum_t        torque_acc_reg [3];
    logic                   sat_seen_reg;
    rbfts_pkg::sum_t        force_acc_next [3];
    rbfts_pkg::sum_t        torque_acc_next [3];
    logic                   sat_seen_next;

    // Result queue.
    rbfts_pkg::result_t                 out_mem_reg [rbfts_pkg::OUT_DEPTH];
    logic [rbfts_pkg::OUT_PTR_W-1:0]    out_wr_ptr_reg;
    logic [rbfts_pkg::OUT_PTR_W-1:0]    out_rd_ptr_reg;
    logic [rbfts_pkg::OUT_CNT_W-1:0]    out_cnt_reg;
    logic                               out_full;
    logic                               out_wr;
    logic                               out_rd;
    rbfts_pkg::result_t                 out_new;

    logic                   commit;
    logic                   adv;

    assign out_full  = (out_cnt_reg == rbfts_pkg::OUT_CNT_W'(rbfts_pkg::OUT_DEPTH));
    assign res_empty = (out_cnt_reg == '0);
    assign res_data  = out_mem_reg[out_rd_ptr_reg];
    assign out_rd    = res_pop && !res_empty;

    assign commit  = d_valid_reg && (!d_last_reg || !out_full);
    assign adv     = !d_valid_reg || commit;
    assign mid_pop = adv && !mid_status.empty;
    assign out_wr  = commit && d_last_reg;

    // Operand pairs for rx/ry/rz cross f.
    assign c_prod_next[0] = 64'(mid_entry.ry) * 64'(mid_entry.fz);
    assign c_prod_next[1] = 64'(mid_entry.rz) * 64'(mid_entry.fy);
    assign c_prod_next[2] = 64'(mid_entry.rz) * 64'(mid_entry.fx);
    assign c_prod_next[3] = 64'(mid_entry.rx) * 64'(mid_entry.fz);
    assign c_prod_next[4] = 64'(mid_entry.rx) * 64'(mid_entry.fy);
    assign c_prod_next[5] = 64'(mid_entry.ry) * 64'(mid_entry.fx);

    always_comb begin
        logic signed [64:0] diff;
        for (int i = 0; i < 3; i++)
        begin
            diff = 65'(c_prod_reg[2*i]) - 65'(c_prod_reg[2*i+1]);
            d_tq_next[i] = diff[64:16];
        end
    end

    always_comb begin
        logic signed [48:0] fsum;
        logic signed [49:0] tsum;
        sat_seen_next = sat_seen_reg || d_sat_reg;
        for (int i = 0; i < 3; i++)
        begin
            fsum = 49'(force_acc_reg[i]) + 49'(d_f_reg[i]);
            if (fsum[48] == fsum[47])
            begin
                force_acc_next[i] = fsum[47:0];
            end
            else
            begin
                force_acc_next[i] = fsum[48] ? rbfts_pkg::SUM_MIN : rbfts_pkg::SUM_MAX;
                sat_seen_next = 1'b1;
            end

            tsum = 50'(torque_acc_reg[i]) + 50'(d_tq_reg[i]);
            if ((&tsum[49:47]) || !(|tsum[49:47]))
            begin
                torque_acc_next[i] = tsum[47:0];
            end
            else
            begin
                torque_acc_next[i] = tsum[49] ? rbfts_pkg::SUM_MIN : rbfts_pkg::SUM_MAX;
                sat_seen_next = 1'b1;
            end
        end
        out_new.fx  = force_acc_next[0];
        out_new.fy  = force_acc_next[1];
        out_new.fz  = force_acc_next[2];
        out_new.tx  = torque_acc_next[0];
        out_new.ty  = torque_acc_next[1];
        out_new.tz  = torque_acc_next[2];
        out_new.ovf = sat_seen_next;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            c_valid_reg  <= 1'b0;
            d_valid_reg  <= 1'b0;
            sat_seen_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                force_acc_reg[i]  <= '0;
                torque_acc_reg[i] <= '0;
            end
            out_wr_ptr_reg <= '0;
            out_rd_ptr_reg <= '0;
            out_cnt_reg    <= '0;
        end
        else
        begin
            if (adv)
            begin
                c_valid_reg <= mid_pop;
                d_valid_reg <= c_valid_reg;
            end
            if (commit)
            begin
                if (d_last_reg)
                begin
                    sat_seen_reg <= 1'b0;
                    for (int i = 0; i < 3; i++)
                    begin
                        force_acc_reg[i]  <= '0;
                        torque_acc_reg[i] <= '0;
                    end
                end
                else
                begin
                    sat_seen_reg   <= sat_seen_next;
                    force_acc_reg  <= force_acc_next;
                    torque_acc_reg <= torque_acc_next;
                end
            end
            if (out_wr)
            begin
                out_wr_ptr_reg <= out_wr_ptr_reg + 1'b1;
            end
            if (out_rd)
            begin
                out_rd_ptr_reg <= out_rd_ptr_reg + 1'b1;
            end
            if (out_wr && !out_rd)
            begin
                out_cnt_reg <= out_cnt_reg + 1'b1;
            end
            else if (out_rd && !out_wr)
            begin
                out_cnt_reg <= out_cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (mid_pop)
        begin
            c_prod_reg <= c_prod_next;
            c_f_reg[0] <= mid_entry.fx;
            c_f_reg[1] <= mid_entry.fy;
            c_f_reg[2] <= mid_entry.fz;
            c_sat_reg  <= mid_entry.sat;
            c_last_reg <= mid_entry.last;
        end
        if (adv)
        begin
            d_tq_reg   <= d_tq_next;
            d_f_reg    <= c_f_reg;
            d_sat_reg  <= c_sat_reg;
            d_last_reg <= c_last_reg;
        end
        if (out_wr)
        begin
            out_mem_reg[out_wr_ptr_reg] <= out_new;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/rigid_body_force_torque_sum.sv
// Top level of the rigid-body net force and torque accumulator.
// Depends on rbfts_pkg, rbfts_front, rbfts_fifo and rbfts_back.
// Throughput: one particle per clock cycle while results are taken.
// A body's sums pass the front stages, the middle queue, the product and term stages and the result queue.
// Reset: asynchronous; empties the pipeline and queues, clears the sums and the overflow
// flag, and sets the box bounds to -16.0 and +16.0 in every axis.
`default_nettype none

// The block accepts one particle request per cycle while full is low, through a queue-style interface.
// The front part registers the particle, forms mass times acceleration with one
// multiplier per axis, then in a second stage floors and saturates the force and
// forms the wrapped centre-of-mass offset. Classified particles wait in a four-entry
// queue. The back part pops them, forms the six cross products in one stage, the
// three torque terms in the next, and then adds force and torque into 48-bit
// saturating sums. The sum update is the only step that depends on the previous
// particle. When a particle closes its body, the sums and the sticky overflow flag
// go to a two-entry result queue and the sums restart from zero. The result queue
// lets the back part keep going while a finished result waits; only a closing
// particle meeting a full result queue stalls it.
module rigid_body_force_torque_sum (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // Configuration writes.
    input  wire logic                               cfg_wr_en,
    input  wire logic [rbfts_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [rbfts_pkg::Q_W-1:0]          cfg_data,
    // Particle requests.
    input  wire logic                               push,
    output logic                                    full,
    input  wire logic [31:0]                        particle_mass,
    input  wire logic signed [31:0]                 accel_x,
    input  wire logic signed [31:0]                 accel_y,
    input  wire logic signed [31:0]                 accel_z,
    input  wire logic signed [31:0]                 pos_x,
    input  wire logic signed [31:0]                 pos_y,
    input  wire logic signed [31:0]                 pos_z,
    input  wire logic signed [31:0]                 centre_x,
    input  wire logic signed [31:0]                 centre_y,
    input  wire logic signed [31:0]                 centre_z,
    input  wire logic                               last_of_body,
    // Result requests.
    output logic                                    empty,
    input  wire logic                               pop,
    output logic signed [47:0]                      net_force_x,
    output logic signed [47:0]                      net_force_y,
    output logic signed [47:0]                      net_force_z,
    output logic signed [47:0]                      net_torque_x,
    output logic signed [47:0]                      net_torque_y,
    output logic signed [47:0]                      net_torque_z,
    output logic                                    sum_overflow
);

    rbfts_pkg::mid_entry_t  front_entry;
    rbfts_pkg::mid_entry_t  back_entry;
    rbfts_pkg::mid_status_t mid_status;
    rbfts_pkg::result_t     result;
    logic                   mid_push;
    logic                   mid_pop;

    rbfts_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_push       (push),
        .in_full       (full),
        .particle_mass (particle_mass),
        .accel_x       (accel_x),
        .accel_y       (accel_y),
        .accel_z       (accel_z),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .pos_z         (pos_z),
        .centre_x      (centre_x),
        .centre_y      (centre_y),
        .centre_z      (centre_z),
        .last_of_body  (last_of_body),
        .mid_status    (mid_status),
        .mid_push      (mid_push),
        .mid_entry     (front_entry)
    );

    // The queue only accepts a push when it has room, which the front already checks.
    rbfts_fifo u_mid_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (mid_push),
        .wr_data (front_entry),
        .rd_en   (mid_pop),
        .rd_data (back_entry),
        .status  (mid_status)
    );

    rbfts_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .mid_entry  (back_entry),
        .mid_status (mid_status),
        .mid_pop    (mid_pop),
        .res_pop    (pop),
        .res_empty  (empty),
        .res_data   (result)
    );

    // The oldest waiting result drives the result ports directly from the queue.
    assign net_force_x  = result.fx;
    assign net_force_y  = result.fy;
    assign net_force_z  = result.fz;
    assign net_torque_x = result.tx;
    assign net_torque_y = result.ty;
    assign net_torque_z = result.tz;
    assign sum_overflow = result.ovf;

endmodule

`default_nettype wire

FILE: rtl/core/rbfts_checker.sv
// Port-level checks for the rigid-body force and torque accumulator, and their binding.
// Depends on rigid_body_force_torque_sum and rbfts_pkg.
`default_nettype none

module rbfts_checker (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               push,
    input  wire logic                               full,
    input  wire logic                               last_of_body,
    input  wire logic                               empty,
    input  wire logic                               pop,
    input  wire logic signed [47:0]                 net_force_x,
    input  wire logic signed [47:0]                 net_force_y,
    input  wire logic signed [47:0]                 net_force_z,
    input  wire logic signed [47:0]                 net_torque_x,
    input  wire logic signed [47:0]                 net_torque_y,
    input  wire logic signed [47:0]                 net_torque_z,
    input  wire logic                               sum_overflow
);

    // Bodies closed at the input but not yet taken at the output.
    logic [4:0] pending_reg;
    logic       closes;
    logic       takes;

    assign closes = push && !full && last_of_body;
    assign takes  = pop && !empty;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else if (closes && !takes)
        begin
            pending_reg <= pending_reg + 1'b1;
        end
        else if (takes && !closes)
        begin
            pending_reg <= pending_reg - 1'b1;
        end
    end

    // Once reset has been seen at an edge, the block has nothing to deliver and room
    // to take a particle.
    a_reset_idle: assert property (@(posedge clk) !rst_n |=> empty && !full)
        else $error("queue flags wrong after reset");

    // A waiting result that is not taken stays unchanged.
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(net_force_x) && $stable(net_force_y)
            && $stable(net_force_z) && $stable(net_torque_x) && $stable(net_torque_y)
            && $stable(net_torque_z) && $stable(sum_overflow)))
        else $error("waiting result changed or vanished");

    // Every result belongs to a body closed earlier.
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> pending_reg != '0)
        else $error("result shown with no closed body pending");

    // A result is never taken that was not announced by a closing particle.
    a_take_counted: assert property (@(posedge clk) disable iff (!rst_n)
        takes |-> (pending_reg != '0))
        else $error("result taken beyond the closed bodies");

endmodule

bind rigid_body_force_torque_sum rbfts_checker u_rbfts_checker (.*);

`default_nettype wire

FILE: sim/rigid_body_force_torque_sum_tb.sv
// Self-checking testbench for rigid_body_force_torque_sum: particle stream in, body sums out.
// Depends on rbfts_pkg and the block itself; a built-in fixed-point predictor works out
// every body's force and torque sums and the overflow flag, and the monitor compares them.
`default_nettype none

module rigid_body_force_torque_sum_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import rbfts_pkg::*;

    // Cycles to let pass once nothing is expected any more: particles that close no body
    // can still sit in the pipeline and the middle queue after the last result is out.
    localparam int SETTLE_CYCLES = 16;

    // Only the first few mismatches are printed; all of them are counted.
    localparam int PRINT_LIMIT = 40;

    localparam q_t          Q_ONE    = 32'sh0001_0000;
    localparam logic [31:0] MASS_MAX = 32'hFFFF_FFFF;

    // Register indexes that name no register; writes to them must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_NONE_LO = REG_BOX_HIGH_Z + 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NONE_HI = '1;

    // One particle request as it goes onto the ports.
    typedef struct packed {
        logic [31:0] mass;
        q_t          ax;
        q_t          ay;
        q_t          az;
        q_t          px;
        q_t          py;
        q_t          pz;
        q_t          cx;
        q_t          cy;
        q_t          cz;
        logic        last;
    } particle_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [Q_W-1:0]       cfg_data  = '0;

    logic        push          = 1'b0;
    logic        full;
    logic [31:0] particle_mass = '0;
    q_t          accel_x       = '0;
    q_t          accel_y       = '0;
    q_t          accel_z       = '0;
    q_t          pos_x         = '0;
    q_t          pos_y         = '0;
    q_t          pos_z         = '0;
    q_t          centre_x      = '0;
    q_t          centre_y      = '0;
    q_t          centre_z      = '0;
    logic        last_of_body  = 1'b0;

    logic empty;
    logic pop = 1'b0;
    sum_t net_force_x;
    sum_t net_force_y;
    sum_t net_force_z;
    sum_t net_torque_x;
    sum_t net_torque_y;
    sum_t net_torque_z;
    logic sum_overflow;

    rigid_body_force_torque_sum dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .push         (push),
        .full         (full),
        .particle_mass(particle_mass),
        .accel_x      (accel_x),
        .accel_y      (accel_y),
        .accel_z      (accel_z),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .centre_x     (centre_x),
        .centre_y     (centre_y),
        .centre_z     (centre_z),
        .last_of_body (last_of_body),
        .empty        (empty),
        .pop          (pop),
        .net_force_x  (net_force_x),
        .net_force_y  (net_force_y),
        .net_force_z  (net_force_z),
        .net_torque_x (net_torque_x),
        .net_torque_y (net_torque_y),
        .net_torque_z (net_torque_z),
        .sum_overflow (sum_overflow)
    );

    always #1 clk = ~clk;

    // Stimulus and expectations shared by the processes below.
    particle_t particles_to_send[$];
    result_t   body_sums_due[$];
    int        mismatches = 0;

    // Percent chance per cycle that either side starts an idle burst; zero turns idling off.
    int idle_pct = 20;

    // Predictor state: its own copy of the box registers, the running sums and the
    // sticky saturation flag, all at their reset values.
    q_t     box_lo[3]  = '{BOX_LOW_RESET, BOX_LOW_RESET, BOX_LOW_RESET};
    q_t     box_hi[3]  = '{BOX_HIGH_RESET, BOX_HIGH_RESET, BOX_HIGH_RESET};
    longint force_sum[3]  = '{0, 0, 0};
    longint torque_sum[3] = '{0, 0, 0};
    bit     clamp_hit = 1'b0;

    // Any clamp, whether of a particle force, an offset or a running sum, raises the flag.
    function automatic longint clamp(longint v, longint lo, longint hi);
        if (v > hi)
        begin
            clamp_hit = 1'b1;
            return hi;
        end
        if (v < lo)
        begin
            clamp_hit = 1'b1;
            return lo;
        end
        return v;
    endfunction

    function automatic q_t fit_q(longint v);
        longint c;
        c = clamp(v, Q_MIN, Q_MAX);
        return c[Q_W-1:0];
    endfunction

    // The offset is wrapped once, with the same two steps whatever the order of the
    // bounds: subtract the box length at or above the upper bound, then add it below
    // the lower bound. Everything is exact in 64 bits before the final clamp.
    function automatic q_t wrapped_offset(q_t p, q_t c, int axis);
        longint lo;
        longint hi;
        longint r;
        lo = box_lo[axis];
        hi = box_hi[axis];
        r  = longint'(p) - longint'(c);
        if (r >= hi)
            r = r - (hi - lo);
        if (r < lo)
            r = r + (hi - lo);
        return fit_q(r);
    endfunction

    // a1*b1 - a2*b2 in Q32.32, floored to Q32.16; it always fits in 64 bits.
    function automatic longint torque_term(q_t a1, q_t b1, q_t a2, q_t b2);
        return (longint'(a1) * longint'(b1) - longint'(a2) * longint'(b2)) >>> 16;
    endfunction

    // Adds one accepted particle into the running sums and, when it closes its body,
    // queues the body's sums and flag and starts the next body from zero.
    function automatic void accumulate_particle(particle_t p);
        q_t      acc[3];
        q_t      pos[3];
        q_t      cen[3];
        q_t      f[3];
        q_t      r[3];
        result_t sums;
        acc = '{p.ax, p.ay, p.az};
        pos = '{p.px, p.py, p.pz};
        cen = '{p.cx, p.cy, p.cz};
        for (int i = 0; i < 3; i++)
        begin
            // Mass is unsigned, so it is zero-extended before the signed multiply.
            f[i] = fit_q((longint'(p.mass) * longint'(acc[i])) >>> 16);
            r[i] = wrapped_offset(pos[i], cen[i], i);
            force_sum[i] = clamp(force_sum[i] + f[i], SUM_MIN, SUM_MAX);
        end
        torque_sum[0] = clamp(torque_sum[0] + torque_term(r[1], f[2], r[2], f[1]),
                              SUM_MIN, SUM_MAX);
        torque_sum[1] = clamp(torque_sum[1] + torque_term(r[2], f[0], r[0], f[2]),
                              SUM_MIN, SUM_MAX);
        torque_sum[2] = clamp(torque_sum[2] + torque_term(r[0], f[1], r[1], f[0]),
                              SUM_MIN, SUM_MAX);
        if (p.last)
        begin
            sums.fx  = force_sum[0][SUM_W-1:0];
            sums.fy  = force_sum[1][SUM_W-1:0];
            sums.fz  = force_sum[2][SUM_W-1:0];
            sums.tx  = torque_sum[0][SUM_W-1:0];
            sums.ty  = torque_sum[1][SUM_W-1:0];
            sums.tz  = torque_sum[2][SUM_W-1:0];
            sums.ovf = clamp_hit;
            body_sums_due.push_back(sums);
            force_sum  = '{0, 0, 0};
            torque_sum = '{0, 0, 0};
            clamp_hit  = 1'b0;
        end
    endfunction

    task automatic report(string msg);
        if (mismatches < PRINT_LIMIT)
            $display("MISMATCH @%0t: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_sum(string name, sum_t got, sum_t want);
        if (got !== want)
            report($sformatf("%s is %0d, should be %0d", name, got, want));
    endtask

    // Drives one register write at the next edge and updates the predictor's copy.
    // The caller lowers the write enable once its writes are done.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, q_t data);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            REG_BOX_LOW_X:  box_lo[0] = data;
            REG_BOX_HIGH_X: box_hi[0] = data;
            REG_BOX_LOW_Y:  box_lo[1] = data;
            REG_BOX_HIGH_Y: box_hi[1] = data;
            REG_BOX_LOW_Z:  box_lo[2] = data;
            REG_BOX_HIGH_Z: box_hi[2] = data;
            default:        ; // no such register, the write has no effect
        endcase
    endtask

    // Returns once every particle has gone in and every body's sums have come out,
    // then lets the pipeline settle so a body left open has reached the sums.
    task automatic wait_until_drained();
        while (particles_to_send.size() != 0 || push || body_sums_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Signed Q16.16 values: some extremes, some full-range, most of them modest in size
    // so that offsets land around the box bounds.
    function automatic q_t rand_q();
        case ($urandom_range(0, 15))
            0:          return Q_MAX;
            1:          return Q_MIN;
            2:          return '0;
            3, 4, 5, 6: return $signed($urandom);
            default:    return $signed($urandom) >>> $urandom_range(8, 28);
        endcase
    endfunction

    function automatic logic [31:0] rand_mass();
        case ($urandom_range(0, 15))
            0:          return MASS_MAX;
            1:          return '0;
            2, 3, 4, 5: return $urandom;
            default:    return $urandom >> $urandom_range(8, 24);
        endcase
    endfunction

    // Queues whole bodies until at least n particles are waiting. Most bodies are short
    // and share one center of mass; a few are long so the sums can grow, and now and
    // then the center drifts within a body. With leave_open the last body is not closed,
    // so its sums carry over into the next phase.
    function automatic void queue_bodies(int n, bit leave_open);
        particle_t p;
        q_t        cx;
        q_t        cy;
        q_t        cz;
        int        body_len;
        int        made;
        made = 0;
        while (made < n)
        begin
            body_len = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 40)
                                                    : $urandom_range(1, 8);
            cx = rand_q();
            cy = rand_q();
            cz = rand_q();
            for (int k = 0; k < body_len; k++)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    cx = rand_q();
                    cy = rand_q();
                    cz = rand_q();
                end
                p.mass = rand_mass();
                p.ax   = rand_q();
                p.ay   = rand_q();
                p.az   = rand_q();
                p.cx   = cx;
                p.cy   = cy;
                p.cz   = cz;
                p.px   = ($urandom_range(0, 3) == 0) ? rand_q() : cx + rand_q();
                p.py   = ($urandom_range(0, 3) == 0) ? rand_q() : cy + rand_q();
                p.pz   = ($urandom_range(0, 3) == 0) ? rand_q() : cz + rand_q();
                p.last = (k == body_len - 1);
                particles_to_send.push_back(p);
            end
            made += body_len;
        end
        if (leave_open)
        begin
            p = particles_to_send.pop_back();
            p.last = 1'b0;
            particles_to_send.push_back(p);
        end
    endfunction

    // Driver: presents particle requests from the queue and holds each one until it is
    // taken. The predictor sees a particle at the edge where the block accepts it.
    particle_t on_port;
    int        send_gap = 0;

    always @(posedge clk)
    begin
        if (push && !full)
            accumulate_particle(on_port);

        if (push && full)
        begin
            // The request is still waiting; leave it on the ports.
        end
        else if (send_gap > 0)
        begin
            send_gap--;
            push <= 1'b0;
        end
        else if (particles_to_send.size() == 0)
        begin
            push <= 1'b0;
        end
        else if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct)
        begin
            // Idle burst; send_gap counts the idle cycles that follow this one.
            send_gap = $urandom_range(0, 4);
            push <= 1'b0;
        end
        else
        begin
            on_port = particles_to_send.pop_front();
            push          <= 1'b1;
            particle_mass <= on_port.mass;
            accel_x       <= on_port.ax;
            accel_y       <= on_port.ay;
            accel_z       <= on_port.az;
            pos_x         <= on_port.px;
            pos_y         <= on_port.py;
            pos_z         <= on_port.pz;
            centre_x      <= on_port.cx;
            centre_y      <= on_port.cy;
            centre_z      <= on_port.cz;
            last_of_body  <= on_port.last;
        end
    end

    // Monitor: takes result requests, with its own idle bursts, and checks each one
    // field by field against the oldest body still due.
    int take_gap = 0;

    always @(posedge clk)
    begin
        result_t due;
        if (rst_n && pop && !empty)
        begin
            if (body_sums_due.size() == 0)
            begin
                report("result came out with no body closed");
            end
            else
            begin
                due = body_sums_due.pop_front();
                check_sum("net_force_x", net_force_x, due.fx);
                check_sum("net_force_y", net_force_y, due.fy);
                check_sum("net_force_z", net_force_z, due.fz);
                check_sum("net_torque_x", net_torque_x, due.tx);
                check_sum("net_torque_y", net_torque_y, due.ty);
                check_sum("net_torque_z", net_torque_z, due.tz);
                if (sum_overflow !== due.ovf)
                    report($sformatf("sum_overflow is %b, should be %b",
                                     sum_overflow, due.ovf));
            end
        end

        if (take_gap > 0)
        begin
            take_gap--;
            pop <= 1'b0;
        end
        else if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct)
        begin
            take_gap = $urandom_range(0, 4);
            pop <= 1'b0;
        end
        else
        begin
            pop <= 1'b1;
        end
    end

    // Main sequence: reset, a directed body set under the reset box, then phases of
    // random bodies, each under its own box. The box is only rewritten once the block
    // has drained, which also makes the sender pause until every result is back.
    initial
    begin
        q_t lo[3];
        q_t hi[3];
        q_t a;
        q_t b;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A body of one all-zero particle, and the smallest negative product rounding down to -1 lsb.
        particles_to_send.push_back(particle_t'{'0, '0, '0, '0, '0, '0, '0,
                                                '0, '0, '0, 1'b1});
        particles_to_send.push_back(particle_t'{32'd1, -32'sd1, -32'sd1, -32'sd1,
                                                '0, '0, '0, '0, '0, '0, 1'b1});
        // The largest mass against extreme accelerations saturates the particle force.
        particles_to_send.push_back(particle_t'{MASS_MAX, Q_MAX, Q_MAX, Q_MAX,
                                                Q_ONE, Q_ONE, Q_ONE, '0, '0, '0, 1'b1});
        particles_to_send.push_back(particle_t'{MASS_MAX, Q_MIN, Q_MIN, Q_MIN,
                                                Q_ONE, -Q_ONE, Q_ONE, '0, '0, '0, 1'b1});
        // One body with offsets on the upper bound, just below the lower bound and on
        // the lower bound: the first two wrap, the last stays.
        particles_to_send.push_back(particle_t'{Q_ONE, Q_ONE, -Q_ONE, Q_ONE,
                                                BOX_HIGH_RESET, BOX_HIGH_RESET,
                                                BOX_HIGH_RESET, '0, '0, '0, 1'b0});
        particles_to_send.push_back(particle_t'{Q_ONE, -Q_ONE, Q_ONE, Q_ONE,
                                                BOX_LOW_RESET - 32'sd1,
                                                BOX_LOW_RESET - 32'sd1,
                                                BOX_LOW_RESET - 32'sd1, '0, '0, '0, 1'b0});
        particles_to_send.push_back(particle_t'{Q_ONE, Q_ONE, Q_ONE, -Q_ONE,
                                                BOX_LOW_RESET, BOX_LOW_RESET,
                                                BOX_LOW_RESET, '0, '0, '0, 1'b1});
        // Offsets that stay out of range after the wrap saturate, both ways.
        particles_to_send.push_back(particle_t'{Q_ONE, Q_ONE, 2 * Q_ONE, 3 * Q_ONE,
                                                Q_MAX, Q_MAX, Q_MAX,
                                                Q_MIN, Q_MIN, Q_MIN, 1'b1});
        particles_to_send.push_back(particle_t'{Q_ONE, -Q_ONE, Q_ONE, -Q_ONE,
                                                Q_MIN, Q_MIN, Q_MIN,
                                                Q_MAX, Q_MAX, Q_MAX, 1'b1});
        // An offset past 32 bits that the wrap brings back into range.
        particles_to_send.push_back(particle_t'{Q_ONE, Q_ONE, -Q_ONE, Q_ONE,
                                                Q_MAX, Q_MAX, Q_MAX,
                                                -Q_ONE, -Q_ONE, -Q_ONE, 1'b1});
        // The largest mass against the smallest positive acceleration.
        particles_to_send.push_back(particle_t'{MASS_MAX, 32'sd1, 32'sd1, 32'sd1,
                                                BOX_HIGH_RESET - 32'sd1,
                                                BOX_HIGH_RESET - 32'sd1,
                                                BOX_HIGH_RESET - 32'sd1,
                                                '0, '0, '0, 1'b1});
        // Large torques with no other clamp drive the torque sums into saturation,
        // first upward, then downward.
        repeat (3)
            particles_to_send.push_back(particle_t'{Q_ONE, Q_MAX, Q_MAX, Q_MAX,
                                                    '0, Q_MAX, Q_MIN, '0, '0, '0, 1'b0});
        particles_to_send[$].last = 1'b1;
        repeat (3)
            particles_to_send.push_back(particle_t'{Q_ONE, Q_MIN, Q_MIN, Q_MIN,
                                                    '0, Q_MAX, Q_MIN, '0, '0, '0, 1'b0});
        particles_to_send[$].last = 1'b1;
        wait_until_drained();

        for (int phase = 0; phase < 8; phase++)
        begin
            for (int axis = 0; axis < 3; axis++)
            begin
                a = rand_q();
                b = rand_q();
                case (phase)
                    0:
                    begin
                        // Widest box: the length needs the full 33 bits.
                        lo[axis] = Q_MIN;
                        hi[axis] = Q_MAX;
                    end
                    1:
                    begin
                        // Misordered box with a negative length.
                        lo[axis] = Q_MAX;
                        hi[axis] = Q_MIN;
                    end
                    2:
                    begin
                        // Zero-length box.
                        lo[axis] = a;
                        hi[axis] = a;
                    end
                    3:
                    begin
                        lo[axis] = -Q_ONE;
                        hi[axis] = Q_ONE;
                    end
                    6:
                    begin
                        lo[axis] = BOX_LOW_RESET;
                        hi[axis] = BOX_HIGH_RESET;
                    end
                    default:
                    begin
                        lo[axis] = (a < b) ? a : b;
                        hi[axis] = (a < b) ? b : a;
                    end
                endcase
            end
            write_reg(REG_BOX_LOW_X, lo[0]);
            write_reg(REG_BOX_HIGH_X, hi[0]);
            write_reg(REG_BOX_LOW_Y, lo[1]);
            write_reg(REG_BOX_HIGH_Y, hi[1]);
            write_reg(REG_BOX_LOW_Z, lo[2]);
            write_reg(REG_BOX_HIGH_Z, hi[2]);
            if (phase == 5)
            begin
                // Writes past the last register must leave the box alone.
                write_reg(REG_NONE_LO, $urandom);
                write_reg(REG_NONE_HI, $urandom);
            end
            @(posedge clk);
            cfg_wr_en <= 1'b0;

            // Some phases run without idling; the last one does not idle at all.
            idle_pct = (phase == 2 || phase == 4 || phase == 7) ? 0 : 20;
            queue_bodies(100, phase == 3);
            wait_until_drained();
        end

        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Watchdog far beyond the slowest correct run.
    initial
    begin
        #400us;
        $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire

FILE: sim.f
rtl/core/rbfts_pkg.sv
rtl/core/rbfts_front.sv
rtl/core/rbfts_fifo.sv
rtl/core/rbfts_back.sv
rtl/core/rigid_body_force_torque_sum.sv
rtl/core/rbfts_checker.sv
sim/rigid_body_force_torque_sum_tb.sv
